>>> rtl/core/scr_pkg.sv
// Package: shared codes, command and status types for the shepherd replacement block.
`default_nettype none
package scr_pkg;

  localparam int SETS_DEF       = 64;
  localparam int WAYS_DEF       = 16;
  localparam int SC_WAYS_DEF    = 4;
  localparam int STAMP_BITS_DEF = 32;

  localparam logic [1:0] ACT_TOUCH  = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_VICTIM = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] KIND_FREE  = 2'd0;
  localparam logic [1:0] KIND_LRU   = 2'd1;
  localparam logic [1:0] KIND_COUNT = 2'd2;

  typedef enum logic [3:0] {
    OP_INIT,
    OP_IDLE,
    OP_NORM,
    OP_READ,
    OP_TOUCH,
    OP_FILL,
    OP_CLR_RD,
    OP_CLR_WR,
    OP_VAL_RD,
    OP_VAL_CHK,
    OP_EMIT_FREE,
    OP_HEAD_RD,
    OP_HEAD_CHK,
    OP_COL_RD,
    OP_COL_CHK,
    OP_VIC_WR
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic j_clr;
    logic j_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       init_last;
    logic       norm_done;
    logic       j_last_way;
    logic       j_last_slot;
    logic       way_invalid;
    logic       head_hit;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/scr_ctrl.sv
// Controller: sequences the clearing pass, touch, fill and victim scans.
`default_nettype none
module scr_ctrl
  import scr_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_INIT      = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_NORM      = 4'd2;
  localparam logic [3:0] S_READ      = 4'd3;
  localparam logic [3:0] S_TOUCH     = 4'd4;
  localparam logic [3:0] S_FILL      = 4'd5;
  localparam logic [3:0] S_CLR_RD    = 4'd6;
  localparam logic [3:0] S_CLR_WR    = 4'd7;
  localparam logic [3:0] S_VAL_RD    = 4'd8;
  localparam logic [3:0] S_VAL_CHK   = 4'd9;
  localparam logic [3:0] S_EMIT_FREE = 4'd10;
  localparam logic [3:0] S_HEAD_RD   = 4'd11;
  localparam logic [3:0] S_HEAD_CHK  = 4'd12;
  localparam logic [3:0] S_COL_RD    = 4'd13;
  localparam logic [3:0] S_COL_CHK   = 4'd14;
  localparam logic [3:0] S_VIC_WR    = 4'd15;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_IDLE;
    cmd_o.load  = 1'b0;
    cmd_o.j_clr = 1'b0;
    cmd_o.j_inc = 1'b0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.op = OP_INIT;
        if (sts_i.init_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.op   = OP_IDLE;
        cmd_o.load = in_valid_i;
        if (in_valid_i) state_d = S_NORM;
      end
      S_NORM: begin
        cmd_o.op = OP_NORM;
        if (sts_i.norm_done) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.op    = OP_READ;
        cmd_o.j_clr = 1'b1;
        unique case (sts_i.act)
          ACT_TOUCH:  state_d = S_TOUCH;
          ACT_FILL:   state_d = S_FILL;
          ACT_VICTIM: state_d = S_VAL_RD;
          default:    state_d = S_IDLE;
        endcase
      end
      S_TOUCH: begin
        cmd_o.op = OP_TOUCH;
        state_d  = S_IDLE;
      end
      S_FILL: begin
        cmd_o.op = OP_FILL;
        state_d  = sts_i.head_hit ? S_CLR_RD : S_IDLE;
      end
      S_CLR_RD: begin
        cmd_o.op = OP_CLR_RD;
        state_d  = S_CLR_WR;
      end
      S_CLR_WR: begin
        cmd_o.op    = OP_CLR_WR;
        cmd_o.j_inc = 1'b1;
        state_d     = sts_i.j_last_way ? S_IDLE : S_CLR_RD;
      end
      S_VAL_RD: begin
        cmd_o.op = OP_VAL_RD;
        state_d  = S_VAL_CHK;
      end
      S_VAL_CHK: begin
        cmd_o.op = OP_VAL_CHK;
        if (sts_i.way_invalid) begin
          state_d = S_EMIT_FREE;
        end else if (sts_i.j_last_way) begin
          cmd_o.j_clr = 1'b1;
          state_d     = S_HEAD_RD;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_VAL_RD;
        end
      end
      S_EMIT_FREE: begin
        cmd_o.op = OP_EMIT_FREE;
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      S_HEAD_RD: begin
        cmd_o.op = OP_HEAD_RD;
        state_d  = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        cmd_o.op = OP_HEAD_CHK;
        if (sts_i.j_last_slot) begin
          cmd_o.j_clr = 1'b1;
          state_d     = S_COL_RD;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_HEAD_RD;
        end
      end
      S_COL_RD: begin
        cmd_o.op = OP_COL_RD;
        state_d  = S_COL_CHK;
      end
      S_COL_CHK: begin
        cmd_o.op = OP_COL_CHK;
        if (sts_i.j_last_way) begin
          state_d = S_VIC_WR;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = S_COL_RD;
        end
      end
      S_VIC_WR: begin
        cmd_o.op = OP_VIC_WR;
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/scr_datapath.sv
// Datapath: way and set memories, scan registers, stamp counter and result register.
`default_nettype none
module scr_datapath
  import scr_pkg::*;
#(
  parameter int SETS       = SETS_DEF,
  parameter int WAYS       = WAYS_DEF,
  parameter int SC_WAYS    = SC_WAYS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  wire  [1:0] action_i,
  input  wire  [5:0] set_index_i,
  input  wire  [3:0] way_index_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [3:0] victim_way_o,
  output logic [1:0] victim_kind_o,
  output logic [1:0] shepherd_slot_o
);

  localparam int SB     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WB     = $clog2(WAYS);
  localparam int SCB    = (SC_WAYS > 1) ? $clog2(SC_WAYS) : 1;
  localparam int JB     = (WB > SCB) ? WB : SCB;
  localparam int MB     = WB + 1;
  localparam int WAB    = SB + WB;
  localparam int WDEPTH = SETS * (2 ** WB);

  localparam logic [WB-1:0] VMASK = WB'(WAYS - 1);

  typedef struct packed {
    logic                         vld;
    logic [STAMP_BITS-1:0]        ins;
    logic [STAMP_BITS-1:0]        acc;
    logic [SC_WAYS-1:0][MB-1:0]   marks;
  } way_ent_t;

  typedef struct packed {
    logic [SC_WAYS-1:0][WB-1:0] cnt;
    logic [SC_WAYS-1:0][WB-1:0] head;
  } set_ent_t;

  way_ent_t way_mem [WDEPTH];
  set_ent_t set_mem [SETS];
  way_ent_t way_rdata_q, way_wdata;
  set_ent_t set_rdata_q, set_wdata, init_set;
  logic [WAB-1:0] way_addr;
  logic [SB-1:0]  set_addr;
  logic           way_we, way_re, set_we, set_re;

  logic [WAB-1:0]        init_q, init_d;
  logic [5:0]            s_q, s_d;
  logic [3:0]            w_q, w_d;
  logic [1:0]            act_q, act_d;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d, op_stamp_q, op_stamp_d;
  logic [JB-1:0]         j_q, j_d;
  logic [SCB-1:0]        fk_q, fk_d, slot_q, slot_d;
  logic [STAMP_BITS-1:0] best_q, best_d, lru_acc_q, lru_acc_d;
  logic [WB-1:0]         lru_way_q, lru_way_d, max_way_q, max_way_d, max_val_q, max_val_d;
  logic                  any_free_q, any_free_d, any_max_q, any_max_d;
  logic                  out_valid_q, out_valid_d, emit;
  logic [3:0]            out_way_d;
  logic [1:0]            out_kind_d, out_slot_d;

  logic [SB-1:0]  sidx;
  logic [WB-1:0]  widx, jw, hsel, vsel;
  logic [SCB-1:0] js, hk;
  logic           hit, norm_done, busy, first;
  logic [MB-1:0]  cmark;

  assign sidx      = SB'(s_q);
  assign widx      = WB'(w_q);
  assign jw        = j_q[WB-1:0];
  assign js        = j_q[SCB-1:0];
  assign hsel      = set_rdata_q.head[js];
  assign norm_done = ({7'd0, s_q} < 13'(SETS)) && ({2'd0, w_q} < 6'(WAYS));
  assign busy      = out_valid_q && out_stall_i;
  assign first     = (j_q == '0);
  assign cmark     = way_rdata_q.marks[slot_q];
  assign vsel      = any_free_q ? lru_way_q : max_way_q;

  always_comb begin
    for (int k = 0; k < SC_WAYS; k++) begin
      init_set.cnt[k]  = '0;
      init_set.head[k] = WB'(k % WAYS);
    end
  end

  always_comb begin
    hit = 1'b0;
    hk  = '0;
    for (int k = 0; k < SC_WAYS; k++) begin
      if (!hit && (set_rdata_q.head[k] == widx)) begin
        hit = 1'b1;
        hk  = SCB'(k);
      end
    end
  end

  always_comb begin
    way_we      = 1'b0;
    way_re      = 1'b0;
    way_addr    = {sidx, widx};
    way_wdata   = way_rdata_q;
    set_we      = 1'b0;
    set_re      = 1'b0;
    set_addr    = sidx;
    set_wdata   = set_rdata_q;
    init_d      = init_q;
    s_d         = s_q;
    w_d         = w_q;
    act_d       = act_q;
    stamp_d     = stamp_q;
    op_stamp_d  = op_stamp_q;
    fk_d        = fk_q;
    slot_d      = slot_q;
    best_d      = best_q;
    lru_acc_d   = lru_acc_q;
    lru_way_d   = lru_way_q;
    max_way_d   = max_way_q;
    max_val_d   = max_val_q;
    any_free_d  = any_free_q;
    any_max_d   = any_max_q;
    emit        = 1'b0;
    out_way_d   = victim_way_o;
    out_kind_d  = victim_kind_o;
    out_slot_d  = shepherd_slot_o;
    unique case (cmd_i.op)
      OP_INIT: begin
        way_addr  = init_q;
        way_we    = 1'b1;
        way_wdata = '0;
        set_addr  = init_q[WAB-1:WB];
        set_we    = (init_q[WB-1:0] == '0);
        set_wdata = init_set;
        init_d    = init_q + 1'b1;
      end
      OP_IDLE: begin
        if (cmd_i.load) begin
          s_d        = set_index_i;
          w_d        = way_index_i;
          act_d      = action_i;
          op_stamp_d = stamp_q;
          stamp_d    = stamp_q + 1'b1;
        end
      end
      OP_NORM: begin
        if ({7'd0, s_q} >= 13'(SETS)) s_d = s_q - 6'(SETS);
        if ({2'd0, w_q} >= 6'(WAYS)) w_d = w_q - 4'(WAYS);
      end
      OP_READ: begin
        way_re = 1'b1;
        set_re = 1'b1;
      end
      OP_TOUCH: begin
        way_we        = 1'b1;
        set_we        = 1'b1;
        way_wdata.acc = op_stamp_q;
        for (int k = 0; k < SC_WAYS; k++) begin
          if (!way_rdata_q.marks[k][WB]) begin
            way_wdata.marks[k] = {1'b1, set_rdata_q.cnt[k] & VMASK};
            set_wdata.cnt[k]   = set_rdata_q.cnt[k] + 1'b1;
          end
        end
      end
      OP_FILL: begin
        way_we        = 1'b1;
        way_wdata.vld = 1'b1;
        way_wdata.ins = op_stamp_q;
        way_wdata.acc = op_stamp_q;
        if (hit) begin
          for (int k = 0; k < SC_WAYS; k++) begin
            way_wdata.marks[k] = {1'b1, {WB{1'b0}}};
          end
          set_wdata.cnt[hk] = '0;
          set_we            = 1'b1;
          fk_d              = hk;
        end
      end
      OP_CLR_RD, OP_VAL_RD, OP_COL_RD: begin
        way_addr = {sidx, jw};
        way_re   = 1'b1;
      end
      OP_CLR_WR: begin
        way_addr               = {sidx, jw};
        way_we                 = 1'b1;
        way_wdata.marks[fk_q]  = '0;
      end
      OP_VAL_CHK: begin
      end
      OP_EMIT_FREE: begin
        if (!busy) begin
          emit       = 1'b1;
          out_way_d  = 4'(jw);
          out_kind_d = KIND_FREE;
          out_slot_d = 2'd0;
        end
      end
      OP_HEAD_RD: begin
        way_addr = {sidx, hsel};
        way_re   = 1'b1;
      end
      OP_HEAD_CHK: begin
        if (first || (way_rdata_q.ins < best_q)) begin
          best_d = way_rdata_q.ins;
          slot_d = js;
        end
      end
      OP_COL_CHK: begin
        if (!cmark[WB]) begin
          if (first || !any_free_q || (way_rdata_q.acc < lru_acc_q)) begin
            lru_way_d = jw;
            lru_acc_d = way_rdata_q.acc;
          end
          any_free_d = 1'b1;
          if (first) any_max_d = 1'b0;
        end else begin
          if (first || !any_max_q || (cmark[WB-1:0] > max_val_q)) begin
            max_val_d = cmark[WB-1:0];
            max_way_d = jw;
          end
          any_max_d = 1'b1;
          if (first) any_free_d = 1'b0;
        end
      end
      OP_VIC_WR: begin
        if (!busy) begin
          set_we                 = 1'b1;
          set_wdata.head[slot_q] = vsel;
          emit                   = 1'b1;
          out_way_d              = 4'(vsel);
          out_kind_d             = any_free_q ? KIND_LRU : KIND_COUNT;
          out_slot_d             = 2'(slot_q);
        end
      end
    endcase
  end

  always_comb begin
    j_d = j_q;
    if (cmd_i.j_clr) begin
      j_d = '0;
    end else if (cmd_i.j_inc) begin
      j_d = j_q + 1'b1;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (way_we) way_mem[way_addr] <= way_wdata;
    if (way_re) way_rdata_q <= way_mem[way_addr];
  end

  always_ff @(posedge clk_i) begin
    if (set_we) set_mem[set_addr] <= set_wdata;
    if (set_re) set_rdata_q <= set_mem[set_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      stamp_q     <= STAMP_BITS'(1);
      j_q         <= '0;
      act_q       <= ACT_TOUCH;
      out_valid_q <= 1'b0;
    end else begin
      init_q      <= init_d;
      stamp_q     <= stamp_d;
      j_q         <= j_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q             <= s_d;
    w_q             <= w_d;
    op_stamp_q      <= op_stamp_d;
    fk_q            <= fk_d;
    slot_q          <= slot_d;
    best_q          <= best_d;
    lru_acc_q       <= lru_acc_d;
    lru_way_q       <= lru_way_d;
    max_way_q       <= max_way_d;
    max_val_q       <= max_val_d;
    any_free_q      <= any_free_d;
    any_max_q       <= any_max_d;
    victim_way_o    <= out_way_d;
    victim_kind_o   <= out_kind_d;
    shepherd_slot_o <= out_slot_d;
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.act         = act_q;
  assign sts_o.init_last   = (init_q == WAB'(WDEPTH - 1));
  assign sts_o.norm_done   = norm_done;
  assign sts_o.j_last_way  = (j_q == JB'(WAYS - 1));
  assign sts_o.j_last_slot = (j_q == JB'(SC_WAYS - 1));
  assign sts_o.way_invalid = !way_rdata_q.vld;
  assign sts_o.head_hit    = hit;
  assign sts_o.out_busy    = busy;

  a_touch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_TOUCH || cmd_i.op == OP_FILL) |-> norm_done)
    else $error("touch or fill with unreduced index");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted item not presented");

  a_victim_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_VIC_WR) |-> (any_free_q || any_max_q))
    else $error("column scan found no way");

endmodule
`default_nettype wire

>>> rtl/core/shepherd_cache_replacement.sv
// Top level: shepherd cache replacement state with controller and datapath.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | action_i, set_index_i, way_index_i
//   out     | output    | out_valid_o / out_stall_i | victim_way_o, victim_kind_o, shepherd_slot_o
//
// Touch, fill: index reduction, a read, a write; a fill that hits a head adds a clearing scan.
// Victim: a scan of the ways for a free one, else a scan of the shepherd heads and a column scan
// of the ways; the single-port way memory is read once per scan step.
// After reset a clearing pass over SETS * 2**clog2(WAYS) way entries runs with in_stall_o high.
// A waiting result holds the block until out_stall_i drops.
`default_nettype none
module shepherd_cache_replacement
  import scr_pkg::*;
#(
  parameter int SETS       = SETS_DEF,
  parameter int WAYS       = WAYS_DEF,
  parameter int SC_WAYS    = SC_WAYS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [1:0] action_i,
  input  wire  [5:0] set_index_i,
  input  wire  [3:0] way_index_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [3:0] victim_way_o,
  output logic [1:0] victim_kind_o,
  output logic [1:0] shepherd_slot_o
);

  cmd_t cmd;
  sts_t sts;

  scr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scr_datapath #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .SC_WAYS    (SC_WAYS),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .set_index_i     (set_index_i),
    .way_index_i     (way_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .victim_way_o    (victim_way_o),
    .victim_kind_o   (victim_kind_o),
    .shepherd_slot_o (shepherd_slot_o)
  );

endmodule
`default_nettype wire

>>> dv/shepherd_cache_replacement_checker.sv
// Checker: watches both channels, predicts victim choices and compares them.
module shepherd_cache_replacement_checker
  import scr_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  wire  [1:0] action_i,
  input  wire  [5:0] set_index_i,
  input  wire  [3:0] way_index_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  wire  [3:0] victim_way_i,
  input  wire  [1:0] victim_kind_i,
  input  wire  [1:0] shepherd_slot_i,
  output int         errors_o,
  output int         pending_o,
  output int         n_free_o,
  output int         n_lru_o,
  output int         n_count_o
);

  typedef struct packed {
    logic [3:0] way;
    logic [1:0] kind;
    logic [1:0] slot;
  } victim_t;

  logic        valid_q   [64][16];
  logic [31:0] ins_q     [64][16];
  logic [31:0] acc_q     [64][16];
  logic        counted_q [64][16][4];
  logic [3:0]  mval_q    [64][16][4];
  logic [3:0]  nextv_q   [64][4];
  logic [3:0]  head_q    [64][4];
  logic [31:0] stamp_q;
  victim_t     victims_q [$];

  task automatic apply_item(input logic [1:0] act, input int s, input int w);
    victim_t v;
    int slot, lru, mx, mxv;
    bit free, anymax, done;
    done = 0;
    case (act)
      ACT_TOUCH: begin
        acc_q[s][w] = stamp_q;
        for (int k = 0; k < 4; k++) begin
          if (!counted_q[s][w][k]) begin
            counted_q[s][w][k] = 1'b1;
            mval_q[s][w][k] = nextv_q[s][k];
            nextv_q[s][k] = nextv_q[s][k] + 4'd1;
          end
        end
      end
      ACT_FILL: begin
        ins_q[s][w] = stamp_q;
        acc_q[s][w] = stamp_q;
        valid_q[s][w] = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (!done && head_q[s][k] == 4'(w)) begin
            done = 1;
            for (int j = 0; j < 4; j++) begin
              counted_q[s][w][j] = 1'b1;
              mval_q[s][w][j] = 4'd0;
            end
            for (int j = 0; j < 16; j++) begin
              counted_q[s][j][k] = 1'b0;
              mval_q[s][j][k] = 4'd0;
            end
            nextv_q[s][k] = 4'd0;
          end
        end
      end
      ACT_VICTIM: begin
        for (int j = 0; j < 16; j++) begin
          if (!done && !valid_q[s][j]) begin
            done = 1;
            v = '{way: 4'(j), kind: KIND_FREE, slot: 2'd0};
          end
        end
        if (!done) begin
          slot = 0; lru = 0; mx = 0; mxv = 0; free = 0; anymax = 0;
          for (int k = 1; k < 4; k++)
            if (ins_q[s][head_q[s][k]] < ins_q[s][head_q[s][slot]]) slot = k;
          for (int j = 0; j < 16; j++) begin
            if (!counted_q[s][j][slot]) begin
              if (!free || acc_q[s][j] < acc_q[s][lru]) lru = j;
              free = 1;
            end else begin
              if (!anymax || int'(mval_q[s][j][slot]) > mxv) begin
                mxv = int'(mval_q[s][j][slot]);
                mx = j;
              end
              anymax = 1;
            end
          end
          if (free) begin
            head_q[s][slot] = 4'(lru);
            v = '{way: 4'(lru), kind: KIND_LRU, slot: 2'(slot)};
          end else begin
            head_q[s][slot] = 4'(mx);
            v = '{way: 4'(mx), kind: KIND_COUNT, slot: 2'(slot)};
          end
        end
        victims_q.push_back(v);
      end
      default: ;
    endcase
    stamp_q = stamp_q + 32'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    victim_t e;
    if (!rst_ni) begin
      for (int s = 0; s < 64; s++) begin
        for (int k = 0; k < 4; k++) begin
          nextv_q[s][k] = 4'd0;
          head_q[s][k] = 4'(k);
        end
        for (int j = 0; j < 16; j++) begin
          valid_q[s][j] = 1'b0;
          ins_q[s][j] = 32'd0;
          acc_q[s][j] = 32'd0;
          for (int k = 0; k < 4; k++) begin
            counted_q[s][j][k] = 1'b0;
            mval_q[s][j][k] = 4'd0;
          end
        end
      end
      stamp_q = 32'd1;
      errors_o <= 0;
      n_free_o <= 0;
      n_lru_o <= 0;
      n_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (victims_q.size() == 0) begin
          $display("%0t: unexpected victim way=%0d kind=%0d slot=%0d", $time,
                   victim_way_i, victim_kind_i, shepherd_slot_i);
          errors_o <= errors_o + 1;
        end else begin
          e = victims_q.pop_front();
          if (e.way !== victim_way_i || e.kind !== victim_kind_i ||
              e.slot !== shepherd_slot_i) begin
            $display("%0t: victim mismatch expected way=%0d kind=%0d slot=%0d, got %0d %0d %0d",
                     $time, e.way, e.kind, e.slot, victim_way_i, victim_kind_i,
                     shepherd_slot_i);
            errors_o <= errors_o + 1;
          end
          case (e.kind)
            KIND_FREE: n_free_o <= n_free_o + 1;
            KIND_LRU:  n_lru_o <= n_lru_o + 1;
            default:   n_count_o <= n_count_o + 1;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i) apply_item(action_i, set_index_i, way_index_i);
    end
    pending_o <= victims_q.size();
  end

endmodule

>>> dv/shepherd_cache_replacement_tb.sv
// Testbench top: drives items into the replacement block and reports the verdict.
module shepherd_cache_replacement_tb;
  import scr_pkg::*;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic [1:0] action_i = ACT_TOUCH;
  logic [5:0] set_index_i = 0;
  logic [3:0] way_index_i = 0;
  logic       out_stall_i = 0;
  wire        in_stall_o, out_valid_o;
  wire  [3:0] victim_way_o;
  wire  [1:0] victim_kind_o, shepherd_slot_o;
  int         errors, pending, n_free, n_lru, n_count, items;
  logic [1:0] act_r;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  shepherd_cache_replacement dut (.*);

  shepherd_cache_replacement_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i, .set_index_i,
    .way_index_i, .out_valid_i(out_valid_o), .out_stall_i, .victim_way_i(victim_way_o),
    .victim_kind_i(victim_kind_o), .shepherd_slot_i(shepherd_slot_o), .errors_o(errors),
    .pending_o(pending), .n_free_o(n_free), .n_lru_o(n_lru), .n_count_o(n_count)
  );

  task automatic send_item(input logic [1:0] act, input logic [5:0] s, input logic [3:0] w);
    bit stalled;
    in_valid_i <= 1;
    action_i <= act;
    set_index_i <= s;
    way_index_i <= w;
    do begin
      @(negedge clk_i) stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    items++;
  endtask

  task automatic pause(input int n);
    in_valid_i <= 0;
    repeat (n) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) < 20) out_stall_i <= 1;
    else if ($urandom_range(0, 99) < 40) out_stall_i <= 0;
  end

  initial begin
    #4_000_000;
    $display("shepherd_cache_replacement regression: fail");
    $finish;
  end

  initial begin
    int burst;
    items = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_item(ACT_VICTIM, 6'd63, 4'd15);
    for (int w = 0; w < 16; w++) send_item(ACT_FILL, 6'd0, 4'(w));
    send_item(ACT_VICTIM, 6'd0, 4'd0);
    send_item(ACT_TOUCH, 6'd0, 4'd15);
    send_item(ACT_NONE, 6'd63, 4'd15);
    send_item(ACT_TOUCH, 6'd63, 4'd0);
    send_item(ACT_VICTIM, 6'd0, 4'd0);
    send_item(ACT_FILL, 6'd0, 4'd1);
    send_item(ACT_VICTIM, 6'd0, 4'd0);
    pause(1);
    wait (pending == 0);
    for (int s = 1; s < 4; s++)
      for (int w = 0; w < 16; w++) send_item(ACT_FILL, 6'(s), 4'(w));
    while (items < 750) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        case ($urandom_range(0, 19))
          0:                 act_r = ACT_NONE;
          1, 2, 3, 4, 5, 6, 7, 8: act_r = ACT_TOUCH;
          9, 10, 11, 12, 13: act_r = ACT_FILL;
          default:           act_r = ACT_VICTIM;
        endcase
        send_item(act_r, ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 3)),
                  4'($urandom_range(0, 15)));
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 40));
      if ($urandom_range(0, 9) == 0) begin
        pause(1);
        wait (pending == 0);
      end
    end
    pause(1);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d items; victims free %0d, lru %0d, by count %0d",
             items, n_free, n_lru, n_count);
    if (errors == 0) $display("shepherd_cache_replacement regression: pass");
    else $display("shepherd_cache_replacement regression: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/core/scr_pkg.sv
rtl/core/scr_ctrl.sv
rtl/core/scr_datapath.sv
rtl/core/shepherd_cache_replacement.sv
dv/shepherd_cache_replacement_checker.sv
dv/shepherd_cache_replacement_tb.sv
